// File: rtl/cbcp_pkg.sv
// Shared widths, constants and control/status types for the B-spline curve point generator.
`default_nettype none
package cbcp_pkg;

  localparam int COORD_W     = 16;
  localparam int STEPS_W     = 6;
  localparam int FRAC_W      = 16;
  localparam int T_W         = 17;
  localparam int NUM_W       = 21;
  localparam int MAG_W       = NUM_W - 1;
  localparam int F_W         = 19;
  localparam int ACC_W       = 38;
  localparam int RECIP_W     = 22;
  localparam int RECIP_SHIFT = 24;
  localparam int DIVP_W      = MAG_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP6      = 22'd2796203;
  localparam logic [T_W-1:0]     ONE_Q       = 17'h10000;
  localparam logic [STEPS_W-1:0] STEPS_RESET = 6'd16;

  localparam logic [1:0] PEN_UP   = 2'd0;
  localparam logic [1:0] PEN_DRAW = 2'd1;
  localparam logic [1:0] PEN_LIFT = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic       load;
    logic       seg_init;
    logic       div_start;
    logic       t_step;
    logic       t2_calc;
    logic       t3_calc;
    logic       num_calc;
    logic       f_calc;
    logic       mac;
    logic [1:0] mac_sel;
    logic       emit_point;
    logic       win_update;
    logic       emit_lift;
  } cbcp_cmd_t;

  typedef struct packed {
    logic gen;
    logic seg_last;
    logic end_flag;
    logic div_done;
    logic out_free;
  } cbcp_sts_t;

endpackage
`default_nettype wire

// File: rtl/cbcp_div.sv
// Restoring divider that forms the unit step 65536 / segment_steps with its remainder.
`default_nettype none
module cbcp_div
  import cbcp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [STEPS_W-1:0] divisor,
  output logic      [T_W-1:0]     quot,
  output logic      [STEPS_W-1:0] rem,
  output logic                    done
);

  localparam int CNT_W = $clog2(T_W);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(T_W - 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [T_W-1:0]     dvd;
  logic [STEPS_W-1:0] dsr;
  logic [STEPS_W:0]   shifted;
  logic               fits;

  assign shifted = {rem, dvd[T_W-1]};
  assign fits    = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == LAST_CNT) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= ONE_Q;
      dsr  <= divisor;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      dvd <= {dvd[T_W-2:0], 1'b0};
      if (fits) begin
        rem  <= STEPS_W'(shifted - {1'b0, dsr});
        quot <= {quot[T_W-2:0], 1'b1};
      end else begin
        rem  <= shifted[STEPS_W-1:0];
        quot <= {quot[T_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/cbcp_dp.sv
// Datapath: point window, parameter stepping, blending weights, multiply-accumulate and result register.
`default_nettype none
module cbcp_dp
  import cbcp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [STEPS_W-1:0] cfg_wdata,
  input  wire coord_t             point_x,
  input  wire coord_t             point_y,
  input  wire logic               curve_start,
  input  wire logic               curve_end,
  input  wire cbcp_cmd_t          cmd,
  output cbcp_sts_t               sts,
  output logic                    curve_valid,
  input  wire logic               curve_stall,
  output coord_t                  out_x,
  output coord_t                  out_y,
  output logic [1:0]              pen_command,
  output logic                    last_of_run
);

  typedef logic signed [NUM_W-1:0] num_t;
  typedef logic signed [F_W-1:0]   wt_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  localparam num_t ONE_NUM = 21'sh10000;

  logic [STEPS_W-1:0] steps;
  coord_t             win_x [3];
  coord_t             win_y [3];
  coord_t             px;
  coord_t             py;
  logic               end_f;
  logic [1:0]         held;
  logic               started;

  logic [T_W-1:0]     q0;
  logic [STEPS_W-1:0] r0;
  logic               div_done;

  logic [T_W-1:0]     t;
  logic [T_W-1:0]     t2;
  logic [T_W-1:0]     t3;
  logic [STEPS_W-1:0] trem;
  logic [STEPS_W-1:0] step_idx;
  logic [STEPS_W:0]   rem_sum;
  logic [STEPS_W:0]   rem_after;
  logic               carry;
  logic [T_W-1:0]     mul_a;
  logic [2*T_W-1:0]   prod;

  num_t tn;
  num_t t2n;
  num_t t3n;
  num_t num [4];
  wt_t  f_next [4];
  wt_t  f [4];

  wt_t    f_sel;
  coord_t px_sel;
  coord_t py_sel;
  acc_t   mx;
  acc_t   my;
  acc_t   acc_x;
  acc_t   acc_y;
  logic   seg_last;

  cbcp_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .divisor (steps),
    .quot    (q0),
    .rem     (r0),
    .done    (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= STEPS_RESET;
    end else if (cfg_we) begin
      steps <= cfg_wdata;
    end
  end

  // Window of held control points and curve state.
  always_ff @(posedge clk) begin
    if (rst) begin
      held    <= '0;
      started <= 1'b0;
      end_f   <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        win_x[k] <= '0;
        win_y[k] <= '0;
      end
    end else if (cmd.emit_lift) begin
      held    <= '0;
      started <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        win_x[k] <= '0;
        win_y[k] <= '0;
      end
    end else if (cmd.load) begin
      px    <= point_x;
      py    <= point_y;
      end_f <= curve_end;
      if (curve_start) begin
        held    <= '0;
        started <= 1'b0;
        for (int k = 0; k < 3; k++) begin
          win_x[k] <= '0;
          win_y[k] <= '0;
        end
      end
    end else if (cmd.win_update) begin
      if (held == 2'd3) begin
        win_x[0] <= win_x[1];
        win_y[0] <= win_y[1];
        win_x[1] <= win_x[2];
        win_y[1] <= win_y[2];
        win_x[2] <= px;
        win_y[2] <= py;
      end else begin
        for (int k = 0; k < 3; k++) begin
          if (held == 2'(k)) begin
            win_x[k] <= px;
            win_y[k] <= py;
          end
        end
        held <= held + 2'd1;
      end
    end else if (cmd.emit_point) begin
      started <= 1'b1;
    end
  end

  // Parameter t advances by the quotient, with the remainder carried along.
  assign rem_sum   = {1'b0, trem} + {1'b0, r0};
  assign carry     = rem_sum >= {1'b0, steps};
  assign rem_after = carry ? rem_sum - {1'b0, steps} : rem_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_idx <= '0;
    end else if (cmd.seg_init) begin
      step_idx <= '0;
    end else if (cmd.t_step) begin
      step_idx <= step_idx + STEPS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seg_init) begin
      t    <= '0;
      trem <= '0;
    end else if (cmd.t_step) begin
      t    <= t + q0 + {{(T_W-1){1'b0}}, carry};
      trem <= rem_after[STEPS_W-1:0];
    end
  end

  assign mul_a = cmd.t3_calc ? t2 : t;
  assign prod  = {{T_W{1'b0}}, mul_a} * {{T_W{1'b0}}, t};

  always_ff @(posedge clk) begin
    if (cmd.t2_calc) begin
      t2 <= prod[FRAC_W+T_W-1:FRAC_W];
    end
    if (cmd.t3_calc) begin
      t3 <= prod[FRAC_W+T_W-1:FRAC_W];
    end
  end

  // Numerators of the four blending weights.
  assign tn  = signed'({{(NUM_W-T_W){1'b0}}, t});
  assign t2n = signed'({{(NUM_W-T_W){1'b0}}, t2});
  assign t3n = signed'({{(NUM_W-T_W){1'b0}}, t3});

  always_ff @(posedge clk) begin
    if (cmd.num_calc) begin
      num[0] <= ONE_NUM - t3n + t2n + t2n + t2n - tn - tn - tn;
      num[1] <= t3n + t3n + t3n - (t2n <<< 2) - (t2n <<< 1) + (ONE_NUM <<< 2);
      num[2] <= ONE_NUM - t3n - t3n - t3n + t2n + t2n + t2n + tn + tn + tn;
      num[3] <= t3n;
    end
  end

  // Signed division by six, truncating toward zero, by a reciprocal multiply.
  always_comb begin
    logic [NUM_W-1:0]  mag;
    logic [DIVP_W-1:0] dp6;
    logic [F_W-2:0]    quo;
    for (int k = 0; k < 4; k++) begin
      mag = num[k][NUM_W-1] ? NUM_W'(-num[k]) : NUM_W'(num[k]);
      dp6 = {{RECIP_W{1'b0}}, mag[MAG_W-1:0]} * {{MAG_W{1'b0}}, RECIP6};
      quo = dp6[RECIP_SHIFT+F_W-2:RECIP_SHIFT];
      f_next[k] = num[k][NUM_W-1] ? -signed'({1'b0, quo}) : signed'({1'b0, quo});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.f_calc) begin
      for (int k = 0; k < 4; k++) begin
        f[k] <= f_next[k];
      end
    end
  end

  // Weighted sum, one control point per cycle.
  always_comb begin
    unique case (cmd.mac_sel)
      2'd0: begin
        px_sel = win_x[0];
        py_sel = win_y[0];
      end
      2'd1: begin
        px_sel = win_x[1];
        py_sel = win_y[1];
      end
      2'd2: begin
        px_sel = win_x[2];
        py_sel = win_y[2];
      end
      default: begin
        px_sel = px;
        py_sel = py;
      end
    endcase
  end

  assign f_sel = f[cmd.mac_sel];
  assign mx = signed'({{(ACC_W-F_W){f_sel[F_W-1]}}, f_sel})
            * signed'({{(ACC_W-COORD_W){px_sel[COORD_W-1]}}, px_sel});
  assign my = signed'({{(ACC_W-F_W){f_sel[F_W-1]}}, f_sel})
            * signed'({{(ACC_W-COORD_W){py_sel[COORD_W-1]}}, py_sel});

  always_ff @(posedge clk) begin
    if (cmd.mac) begin
      acc_x <= ((cmd.mac_sel == 2'd0) ? acc_t'(0) : acc_x) + mx;
      acc_y <= ((cmd.mac_sel == 2'd0) ? acc_t'(0) : acc_y) + my;
    end
  end

  function automatic coord_t to_coord(input acc_t a);
    acc_t shq;
    acc_t qv;
    shq = a >>> FRAC_W;
    qv  = shq + ACC_W'((a[ACC_W-1] && (a[FRAC_W-1:0] != '0)) ? 1 : 0);
    if ((&qv[ACC_W-1:COORD_W-1]) || !(|qv[ACC_W-1:COORD_W-1])) begin
      return qv[COORD_W-1:0];
    end else if (qv[ACC_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  assign seg_last = step_idx == steps;

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      curve_valid <= 1'b0;
    end else if (cmd.emit_point || cmd.emit_lift) begin
      curve_valid <= 1'b1;
    end else if (!curve_stall) begin
      curve_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_point) begin
      out_x       <= to_coord(acc_x);
      out_y       <= to_coord(acc_y);
      pen_command <= started ? PEN_DRAW : PEN_UP;
      last_of_run <= seg_last && !end_f;
    end else if (cmd.emit_lift) begin
      out_x       <= '0;
      out_y       <= '0;
      pen_command <= PEN_LIFT;
      last_of_run <= 1'b1;
    end
  end

  assign sts.gen      = (held == 2'd3) && (steps != '0);
  assign sts.seg_last = seg_last;
  assign sts.end_flag = end_f;
  assign sts.div_done = div_done;
  assign sts.out_free = !curve_valid || !curve_stall;

endmodule
`default_nettype wire

// File: rtl/cbcp_ctrl.sv
// Controller state machine that sequences the datapath for each control point.
`default_nettype none
module cbcp_ctrl
  import cbcp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      point_valid,
  output logic           point_stall,
  input  wire cbcp_sts_t sts,
  output cbcp_cmd_t      cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CHECK  = 4'd1;
  localparam logic [3:0] ST_DIV    = 4'd2;
  localparam logic [3:0] ST_TSTEP  = 4'd3;
  localparam logic [3:0] ST_T2     = 4'd4;
  localparam logic [3:0] ST_T3     = 4'd5;
  localparam logic [3:0] ST_NUM    = 4'd6;
  localparam logic [3:0] ST_FDIV   = 4'd7;
  localparam logic [3:0] ST_MAC    = 4'd8;
  localparam logic [3:0] ST_EMIT   = 4'd9;
  localparam logic [3:0] ST_UPDATE = 4'd10;
  localparam logic [3:0] ST_LIFT   = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [1:0] mac_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      mac_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_MAC) begin
        mac_cnt <= mac_cnt + 2'd1;
      end else begin
        mac_cnt <= '0;
      end
    end
  end

  assign point_stall = state != ST_IDLE;

  always_comb begin
    cmd         = '0;
    cmd.mac_sel = mac_cnt;
    state_next  = state;
    unique case (state)
      ST_IDLE: begin
        if (point_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.gen) begin
          cmd.div_start = 1'b1;
          cmd.seg_init  = 1'b1;
          state_next    = ST_DIV;
        end else begin
          state_next = ST_UPDATE;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_next = ST_TSTEP;
        end
      end
      ST_TSTEP: begin
        cmd.t_step = 1'b1;
        state_next = ST_T2;
      end
      ST_T2: begin
        cmd.t2_calc = 1'b1;
        state_next  = ST_T3;
      end
      ST_T3: begin
        cmd.t3_calc = 1'b1;
        state_next  = ST_NUM;
      end
      ST_NUM: begin
        cmd.num_calc = 1'b1;
        state_next   = ST_FDIV;
      end
      ST_FDIV: begin
        cmd.f_calc = 1'b1;
        state_next = ST_MAC;
      end
      ST_MAC: begin
        cmd.mac = 1'b1;
        if (mac_cnt == 2'd3) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_point = 1'b1;
          state_next     = sts.seg_last ? ST_UPDATE : ST_TSTEP;
        end
      end
      ST_UPDATE: begin
        cmd.win_update = 1'b1;
        state_next     = sts.end_flag ? ST_LIFT : ST_IDLE;
      end
      ST_LIFT: begin
        if (sts.out_free) begin
          cmd.emit_lift = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/cubic_bspline_curve_points_core.sv
// Top level of the uniform cubic B-spline curve point generator.
// A point that completes a window of four runs a step division by segment_steps, then forms
// each curve point through one multiply-accumulate datapath, held longer if the result
// register is held by curve_stall. Other points only update the window, plus a pen lift
// at curve end. Reset clears the window and state, and sets segment_steps to 16.
`default_nettype none
module cubic_bspline_curve_points_core
  import cbcp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [STEPS_W-1:0] cfg_wdata,
  input  wire logic               point_valid,
  output logic                    point_stall,
  input  wire coord_t             point_x,
  input  wire coord_t             point_y,
  input  wire logic               curve_start,
  input  wire logic               curve_end,
  output logic                    curve_valid,
  input  wire logic               curve_stall,
  output coord_t                  out_x,
  output coord_t                  out_y,
  output logic [1:0]              pen_command,
  output logic                    last_of_run
);

  cbcp_cmd_t cmd;
  cbcp_sts_t sts;

  cbcp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  cbcp_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .point_x     (point_x),
    .point_y     (point_y),
    .curve_start (curve_start),
    .curve_end   (curve_end),
    .cmd         (cmd),
    .sts         (sts),
    .curve_valid (curve_valid),
    .curve_stall (curve_stall),
    .out_x       (out_x),
    .out_y       (out_y),
    .pen_command (pen_command),
    .last_of_run (last_of_run)
  );

endmodule
`default_nettype wire
